// ===== hw/rtl/hpbh_pkg.sv =====
package hpbh_pkg;

   localparam int TABLE_AW    = 15;
   localparam int TABLE_DEPTH = 1 << TABLE_AW;
   localparam int PEND_AW     = 12;
   localparam int PEND_DEPTH  = 1 << PEND_AW;
   localparam int LEN_W       = PEND_AW + 1;
   localparam int BLOCK_W     = 27;
   localparam int ENTRY_W     = BLOCK_W + 2;

   localparam logic [31:0] HASH_MUL   = 32'd2654435761;
   localparam logic [15:0] SLOW_RESET = 16'd25;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_FIELD  = 2'd1;
   localparam logic [1:0] CMD_REPORT = 2'd2;
   localparam logic [1:0] CMD_SPARE  = 2'd3;

   localparam logic [2:0] FIN_NONE   = 3'd0;
   localparam logic [2:0] FIN_PLAIN  = 3'd1;
   localparam logic [2:0] FIN_HIT    = 3'd2;
   localparam logic [2:0] FIN_FULL   = 3'd3;
   localparam logic [2:0] FIN_FIELD  = 3'd4;
   localparam logic [2:0] FIN_REPORT = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        core;
      logic [31:0] pc;
      logic [63:0] cycle_count;
      logic [15:0] elapsed_ms;
      logic        consecutive;
   } req_type;

   typedef struct packed {
      logic [14:0] entry_index;
      logic        queued;
      logic        table_full;
      logic [12:0] pending_count;
      logic        committed;
      logic        report_valid;
      logic        report_core;
      logic [31:0] report_block_pc;
      logic [31:0] report_hits;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       clr_step;
      logic       ent_rd;
      logic       ent_rd_best;
      logic       probe_next;
      logic       ins_write;
      logic       append;
      logic       pend_rd;
      logic       walk_hrd;
      logic       walk_hwr;
      logic       len_clear;
      logic       scan_step;
      logic [2:0] fin;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       sample_go;
      logic       commit_go;
      logic       ent_empty;
      logic       ent_match;
      logic       probe_last;
      logic       walk_last;
      logic       len_zero;
      logic       scan_done;
      logic       clr_last;
      logic       out_busy;
   } dp_sts_type;

endpackage

// ===== hw/rtl/hpbh_if.sv =====
interface hpbh_req_if;
   logic             valid;
   logic             ready;
   hpbh_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hpbh_rsp_if;
   logic             valid;
   logic             ready;
   hpbh_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hashed_pc_block_histogram_top.sv =====
// channel   | dir | handshake      | payload
// req_ch    | in  | valid/ready    | cmd, core, pc, cycle_count, elapsed_ms, consecutive
// rsp_ch    | out | valid/ready    | entry_index .. report_hits
// csr       | in  | csr_wr_en      | slow_field_ms
//
// After reset a pass clears every table entry; no transfer is taken meanwhile.
// Sample: probe steps read, then check (single table read port); ignored: no probe.
// Field end: per pending entry, read the pending list, then read and write its hit count.
// Report: one hit count read per cycle across the table.
// A result waits in the output register; a stalled result holds the next finish.
module hashed_pc_block_histogram_top (
   input logic        clock,
   input logic        reset,
   hpbh_req_if.sink   req_ch,
   hpbh_rsp_if.source rsp_ch,
   input logic        csr_wr_en,
   input logic [15:0] csr_wr_data
);
   hpbh_pkg::dp_cmd_type cmd;
   hpbh_pkg::dp_sts_type sts;

   hpbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   hpbh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_ch.data),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_data    (rsp_ch.data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.data.pending_count <= 13'(hpbh_pkg::PEND_DEPTH))
      else $error("pending count beyond list depth");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.data.queued && rsp_ch.data.table_full))
      else $error("queued and table full together");

   a_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.data.report_valid |-> rsp_ch.data.report_hits != 32'd0)
      else $error("report with zero hits");

   a_field: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.data.committed |-> rsp_ch.data.pending_count == 13'd0)
      else $error("commit left pending entries");

endmodule

// ===== hw/rtl/hpbh_dp.sv =====
module hpbh_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  hpbh_pkg::req_type    req_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output hpbh_pkg::rsp_type    rsp_data,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  hpbh_pkg::dp_cmd_type cmd,
   output hpbh_pkg::dp_sts_type sts
);
   localparam int AW = hpbh_pkg::TABLE_AW;
   localparam int PW = hpbh_pkg::PEND_AW;
   localparam int LW = hpbh_pkg::LEN_W;
   localparam int EW = hpbh_pkg::ENTRY_W;

   logic [EW-1:0] entry_mem [hpbh_pkg::TABLE_DEPTH];
   logic [31:0]   hits_mem  [hpbh_pkg::TABLE_DEPTH];
   logic [AW-1:0] pend_mem  [hpbh_pkg::PEND_DEPTH];

   hpbh_pkg::req_type item_ff;
   logic          go_ff, go_in;
   logic [63:0]   last_ff [2];
   logic [15:0]   slow_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] probe_ff;
   logic [LW-1:0] len_ff, len_in;
   logic [PW-1:0] wptr_ff;
   logic [AW:0]   scan_ff;
   logic          scan_v_ff, scan_v_in;
   logic [AW-1:0] scan_addr_ff;
   logic [AW-1:0] best_idx_ff;
   logic [31:0]   best_hits_ff;
   logic [AW-1:0] clr_ff;
   logic [EW-1:0] ent_q;
   logic [31:0]   hits_q;
   logic [AW-1:0] pend_q;
   logic          rsp_valid_ff, rsp_valid_in;
   hpbh_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [2*AW-1:0] prod;
   logic            ent_we, hits_we, hits_re, scan_issue;
   logic [AW-1:0]   ent_waddr, ent_raddr, hits_waddr, hits_raddr;
   logic [EW-1:0]   ent_wdata;
   logic [31:0]     hits_wdata;
   logic            rep_nonzero;

   assign prod   = req_data.pc[AW+4:5] * hpbh_pkg::HASH_MUL[AW-1:0];
   assign idx_in = prod[AW-1:0] + AW'(req_data.core);
   assign go_in  = (req_data.cycle_count != last_ff[req_data.core]) && (req_data.pc != 32'd0)
                   && (len_ff < LW'(hpbh_pkg::PEND_DEPTH));
   assign scan_issue  = cmd.scan_step && !scan_ff[AW];
   assign scan_v_in   = scan_issue;
   assign rep_nonzero = best_hits_ff != 32'd0;

   always_comb begin
      len_in = len_ff;
      if (cmd.append) begin
         len_in = len_ff + LW'(1);
      end else if (cmd.len_clear) begin
         len_in = '0;
      end
   end

   always_comb begin
      ent_we    = cmd.clr_step || cmd.ins_write;
      ent_waddr = cmd.clr_step ? clr_ff : idx_ff;
      ent_wdata = cmd.clr_step ? '0 : {1'b1, item_ff.core, item_ff.pc[31:5]};
      ent_raddr = cmd.ent_rd_best ? best_idx_ff : idx_ff;
      hits_we    = 1'b0;
      hits_waddr = clr_ff;
      hits_wdata = 32'd0;
      if (cmd.clr_step) begin
         hits_we = 1'b1;
      end else if (cmd.walk_hwr) begin
         hits_we    = 1'b1;
         hits_waddr = pend_q;
         hits_wdata = (hits_q == 32'hFFFF_FFFF) ? hits_q : hits_q + 32'd1;
      end else if (cmd.fin == hpbh_pkg::FIN_REPORT && rep_nonzero) begin
         hits_we    = 1'b1;
         hits_waddr = best_idx_ff;
      end
      hits_re    = cmd.walk_hrd || scan_issue;
      hits_raddr = cmd.walk_hrd ? pend_q : scan_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_waddr] <= ent_wdata;
      end
      if (cmd.ent_rd) begin
         ent_q <= entry_mem[ent_raddr];
      end
      if (hits_we) begin
         hits_mem[hits_waddr] <= hits_wdata;
      end
      if (hits_re) begin
         hits_q <= hits_mem[hits_raddr];
      end
      if (cmd.append) begin
         pend_mem[len_ff[PW-1:0]] <= idx_ff;
      end
      if (cmd.pend_rd) begin
         pend_q <= pend_mem[wptr_ff];
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.fin != hpbh_pkg::FIN_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in.pending_count = 13'(len_in);
         case (cmd.fin)
            hpbh_pkg::FIN_HIT: begin
               rsp_data_in.entry_index = 15'(idx_ff);
               rsp_data_in.queued      = 1'b1;
            end
            hpbh_pkg::FIN_FULL: begin
               rsp_data_in.table_full = 1'b1;
            end
            hpbh_pkg::FIN_FIELD: begin
               rsp_data_in.committed = sts.commit_go;
            end
            hpbh_pkg::FIN_REPORT: begin
               if (rep_nonzero) begin
                  rsp_data_in.report_valid    = 1'b1;
                  rsp_data_in.report_core     = ent_q[EW-2];
                  rsp_data_in.report_block_pc = {ent_q[hpbh_pkg::BLOCK_W-1:0], 5'd0};
                  rsp_data_in.report_hits     = best_hits_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         item_ff <= req_data;
         idx_ff  <= idx_in;
         go_ff   <= go_in;
      end else if (cmd.probe_next) begin
         idx_ff <= idx_ff + AW'(1);
      end
      if (scan_v_ff && hits_q > best_hits_ff) begin
         best_hits_ff <= hits_q;
         best_idx_ff  <= scan_addr_ff;
      end else if (cmd.load) begin
         best_hits_ff <= 32'd0;
         best_idx_ff  <= '0;
      end
      if (scan_issue) begin
         scan_addr_ff <= scan_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff[0]   <= 64'd0;
         last_ff[1]   <= 64'd0;
         slow_ff      <= hpbh_pkg::SLOW_RESET;
         probe_ff     <= '0;
         len_ff       <= '0;
         wptr_ff      <= '0;
         scan_ff      <= '0;
         scan_v_ff    <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slow_ff <= csr_wr_data;
         end
         if (cmd.load && req_data.cmd == hpbh_pkg::CMD_SAMPLE) begin
            last_ff[req_data.core] <= req_data.cycle_count;
         end
         if (cmd.load) begin
            probe_ff <= '0;
            wptr_ff  <= '0;
            scan_ff  <= '0;
         end else begin
            if (cmd.probe_next) begin
               probe_ff <= probe_ff + AW'(1);
            end
            if (cmd.walk_hwr) begin
               wptr_ff <= wptr_ff + PW'(1);
            end
            if (scan_issue) begin
               scan_ff <= scan_ff + (AW+1)'(1);
            end
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         scan_v_ff    <= scan_v_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      sts.cmd        = item_ff.cmd;
      sts.sample_go  = go_ff;
      sts.commit_go  = item_ff.consecutive && (item_ff.elapsed_ms >= slow_ff);
      sts.ent_empty  = !ent_q[EW-1];
      sts.ent_match  = (ent_q[EW-2:0] == {item_ff.core, item_ff.pc[31:5]});
      sts.probe_last = &probe_ff;
      sts.walk_last  = (LW'(wptr_ff) + LW'(1)) == len_ff;
      sts.len_zero   = len_ff == '0;
      sts.scan_done  = scan_ff[AW] && !scan_v_ff;
      sts.clr_last   = &clr_ff;
      sts.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/hpbh_ctrl.sv =====
module hpbh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output hpbh_pkg::dp_cmd_type cmd,
   input  hpbh_pkg::dp_sts_type sts
);
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_DISP    = 4'd2;
   localparam logic [3:0] ST_PRB_RD  = 4'd3;
   localparam logic [3:0] ST_PRB_CHK = 4'd4;
   localparam logic [3:0] ST_WLK_PRD = 4'd5;
   localparam logic [3:0] ST_WLK_HRD = 4'd6;
   localparam logic [3:0] ST_WLK_HWR = 4'd7;
   localparam logic [3:0] ST_FLD_FIN = 4'd8;
   localparam logic [3:0] ST_SCAN    = 4'd9;
   localparam logic [3:0] ST_REP_RD  = 4'd10;
   localparam logic [3:0] ST_REP_FIN = 4'd11;
   localparam logic [3:0] ST_PLAIN   = 4'd12;

   logic [3:0] state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.fin  = hpbh_pkg::FIN_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            case (sts.cmd)
               hpbh_pkg::CMD_SAMPLE: state_in = sts.sample_go ? ST_PRB_RD : ST_PLAIN;
               hpbh_pkg::CMD_FIELD:
                  state_in = (sts.commit_go && !sts.len_zero) ? ST_WLK_PRD : ST_FLD_FIN;
               hpbh_pkg::CMD_REPORT: state_in = ST_SCAN;
               default: state_in = ST_PLAIN;
            endcase
         end
         ST_PRB_RD: begin
            cmd.ent_rd = 1'b1;
            state_in   = ST_PRB_CHK;
         end
         ST_PRB_CHK: begin
            if (sts.ent_empty || sts.ent_match) begin
               if (!sts.out_busy) begin
                  cmd.ins_write = sts.ent_empty;
                  cmd.append    = 1'b1;
                  cmd.fin       = hpbh_pkg::FIN_HIT;
                  state_in      = ST_IDLE;
               end
            end else if (sts.probe_last) begin
               if (!sts.out_busy) begin
                  cmd.fin  = hpbh_pkg::FIN_FULL;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_PRB_RD;
            end
         end
         ST_WLK_PRD: begin
            cmd.pend_rd = 1'b1;
            state_in    = ST_WLK_HRD;
         end
         ST_WLK_HRD: begin
            cmd.walk_hrd = 1'b1;
            state_in     = ST_WLK_HWR;
         end
         ST_WLK_HWR: begin
            cmd.walk_hwr = 1'b1;
            state_in     = sts.walk_last ? ST_FLD_FIN : ST_WLK_PRD;
         end
         ST_FLD_FIN: begin
            if (!sts.out_busy) begin
               cmd.len_clear = 1'b1;
               cmd.fin       = hpbh_pkg::FIN_FIELD;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_REP_RD;
            end
         end
         ST_REP_RD: begin
            cmd.ent_rd      = 1'b1;
            cmd.ent_rd_best = 1'b1;
            state_in        = ST_REP_FIN;
         end
         ST_REP_FIN: begin
            if (!sts.out_busy) begin
               cmd.fin  = hpbh_pkg::FIN_REPORT;
               state_in = ST_IDLE;
            end
         end
         ST_PLAIN: begin
            if (!sts.out_busy) begin
               cmd.fin  = hpbh_pkg::FIN_PLAIN;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
